// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers used by palette_nearest_color_search_unit
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// condition must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst, cond)
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// File: hdl/pncs_pkg.sv
// ----------------------------------------------------------------------------
// pncs_pkg
// shared widths, request codes and pipeline tag type of the palette search
// ----------------------------------------------------------------------------
package pncs_pkg;

   localparam int CHAN_W  = 8;
   localparam int IDX_W   = 8;
   localparam int SIZE_W  = 9;
   localparam int SQ_W    = 16;
   localparam int DIST_W  = 18;
   localparam int COLOR_W = 3 * CHAN_W;

   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   // travels alongside an entry through the read and distance stages
   typedef struct packed {
      logic             valid;
      logic [IDX_W-1:0] index;
   } tag_type;

endpackage

// File: hdl/pncs_ram.sv
// ----------------------------------------------------------------------------
// pncs_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module pncs_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/pncs_dist.sv
// ----------------------------------------------------------------------------
// pncs_dist
// per-channel squared differences, registered, summed into the distance
// ----------------------------------------------------------------------------
module pncs_dist (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                clear,
   input  logic [pncs_pkg::CHAN_W-1:0]         query_red,
   input  logic [pncs_pkg::CHAN_W-1:0]         query_green,
   input  logic [pncs_pkg::CHAN_W-1:0]         query_blue,
   input  logic [pncs_pkg::COLOR_W-1:0]        entry_color,
   input  pncs_pkg::tag_type                   in_tag,
   output pncs_pkg::tag_type                   out_tag,
   output logic [pncs_pkg::DIST_W-1:0]         out_dist
);

   import pncs_pkg::*;

   logic [CHAN_W-1:0] diff_r, diff_g, diff_b;
   logic [CHAN_W-1:0] ent_r, ent_g, ent_b;
   logic [SQ_W-1:0]   sq_r_ff, sq_g_ff, sq_b_ff;
   logic [SQ_W-1:0]   sq_r_in, sq_g_in, sq_b_in;
   tag_type           tag_ff, tag_in;

   assign ent_r = entry_color[3*CHAN_W-1:2*CHAN_W];
   assign ent_g = entry_color[2*CHAN_W-1:CHAN_W];
   assign ent_b = entry_color[CHAN_W-1:0];

   always_comb begin
      diff_r  = (ent_r > query_red)   ? ent_r - query_red   : query_red - ent_r;
      diff_g  = (ent_g > query_green) ? ent_g - query_green : query_green - ent_g;
      diff_b  = (ent_b > query_blue)  ? ent_b - query_blue  : query_blue - ent_b;
      sq_r_in = SQ_W'(diff_r) * SQ_W'(diff_r);
      sq_g_in = SQ_W'(diff_g) * SQ_W'(diff_g);
      sq_b_in = SQ_W'(diff_b) * SQ_W'(diff_b);
      tag_in        = in_tag;
      tag_in.valid  = in_tag.valid & ~clear;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0;
      end else begin
         tag_ff <= tag_in;
      end
      sq_r_ff <= sq_r_in;
      sq_g_ff <= sq_g_in;
      sq_b_ff <= sq_b_in;
   end

   assign out_tag  = tag_ff;
   assign out_dist = DIST_W'(sq_r_ff) + DIST_W'(sq_g_ff) + DIST_W'(sq_b_ff);

endmodule

// File: hdl/palette_nearest_color_search_unit.sv
// ----------------------------------------------------------------------------
// palette_nearest_color_search_unit
// nearest color search over an rgb palette held in a synchronous ram
// ----------------------------------------------------------------------------
// Request channel (req_valid / req_stall): req_type selects a palette write
// (entry_index gets the rgb value, no response) or a query (rgb color, one
// response on rsp_valid / rsp_stall carrying the index of the nearest entry).
// csr_wr_en / csr_wr_data set palette_size, the number of entries searched;
// values above PALETTE_DEPTH search the whole palette, zero answers index 0.
// Write only while no query is pending.
// A query scans the palette ram one entry per cycle through a read stage
// and a squared-difference stage; an exact match ends the scan at that
// entry. One request is worked on at a time; the ram read port sets the
// scan rate.
// The response sits in an output register: while the receiver stalls, new
// writes and a new query are still taken, and a finished query waits for the
// register to free. Reset returns palette_size to 256 and empties the
// pipeline; palette contents are undefined until written.
// ----------------------------------------------------------------------------
module palette_nearest_color_search_unit #(
   parameter int PALETTE_DEPTH = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_type,
   input  logic [pncs_pkg::IDX_W-1:0]    req_entry_index,
   input  logic [pncs_pkg::CHAN_W-1:0]   req_red,
   input  logic [pncs_pkg::CHAN_W-1:0]   req_green,
   input  logic [pncs_pkg::CHAN_W-1:0]   req_blue,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [pncs_pkg::IDX_W-1:0]    rsp_color_index,
   input  logic                          csr_wr_en,
   input  logic [pncs_pkg::SIZE_W-1:0]   csr_wr_data
);

   import pncs_pkg::*;

`include "assert_macros.svh"

   localparam int ADDR_W = $clog2(PALETTE_DEPTH);
   localparam logic [SIZE_W-1:0] DEPTH_CNT = SIZE_W'(PALETTE_DEPTH);
   localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(256);
   localparam logic [DIST_W-1:0] DIST_INIT = '1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   state_type          state_ff, state_in;
   logic [SIZE_W-1:0]  size_ff, size_in;
   logic [SIZE_W-1:0]  count_ff, count_in;
   logic [SIZE_W-1:0]  issue_ff, issue_in;
   logic [CHAN_W-1:0]  qr_ff, qg_ff, qb_ff;
   logic [CHAN_W-1:0]  qr_in, qg_in, qb_in;
   logic [DIST_W-1:0]  best_ff, best_in;
   logic [IDX_W-1:0]   pick_ff, pick_in;
   tag_type            rd_tag_ff, rd_tag_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]   rsp_index_ff, rsp_index_in;

   logic               accept;
   logic               issue;
   logic [SIZE_W-1:0]  req_count;
   logic               ram_wr_en;
   logic [COLOR_W-1:0] ram_rd_data;
   tag_type            dist_tag;
   logic [DIST_W-1:0]  entry_dist;
   logic               rsp_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid & ~req_stall;
   assign req_count = (size_ff > DEPTH_CNT) ? DEPTH_CNT : size_ff;
   assign issue     = (state_ff == ST_SCAN) && (issue_ff < count_ff);
   assign ram_wr_en = accept && (req_type == REQ_WRITE) &&
                      ({1'b0, req_entry_index} < DEPTH_CNT);
   assign rsp_free  = ~rsp_valid_ff | ~rsp_stall;

   // writes happen only in idle and reads only in scan, so no ram forwarding
   pncs_ram #(
      .WIDTH (COLOR_W),
      .DEPTH (PALETTE_DEPTH)
   ) u_palette (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (req_entry_index[ADDR_W-1:0]),
      .wr_data ({req_red, req_green, req_blue}),
      .rd_en   (issue),
      .rd_addr (issue_ff[ADDR_W-1:0]),
      .rd_data (ram_rd_data)
   );

   pncs_dist u_dist (
      .clock       (clock),
      .reset       (reset),
      .clear       (state_ff != ST_SCAN),
      .query_red   (qr_ff),
      .query_green (qg_ff),
      .query_blue  (qb_ff),
      .entry_color (ram_rd_data),
      .in_tag      (rd_tag_ff),
      .out_tag     (dist_tag),
      .out_dist    (entry_dist)
   );

   always_comb begin
      state_in     = state_ff;
      size_in      = size_ff;
      count_in     = count_ff;
      issue_in     = issue_ff;
      qr_in        = qr_ff;
      qg_in        = qg_ff;
      qb_in        = qb_ff;
      best_in      = best_ff;
      pick_in      = pick_ff;
      rsp_index_in = rsp_index_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rd_tag_in.valid = issue;
      rd_tag_in.index = issue_ff[IDX_W-1:0];

      if (csr_wr_en) begin
         size_in = csr_wr_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_type == REQ_QUERY)) begin
               qr_in    = req_red;
               qg_in    = req_green;
               qb_in    = req_blue;
               count_in = req_count;
               issue_in = '0;
               best_in  = DIST_INIT;
               pick_in  = '0;
               state_in = (req_count == '0) ? ST_FINISH : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (issue) begin
               issue_in = issue_ff + SIZE_W'(1);
            end
            if (dist_tag.valid && (entry_dist < best_ff)) begin
               pick_in = dist_tag.index;
               best_in = entry_dist;
            end
            // exact match ends the scan, later entries cannot win
            if (dist_tag.valid && (entry_dist == '0)) begin
               state_in = ST_FINISH;
            end else if (!issue && !rd_tag_ff.valid && !dist_tag.valid) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = pick_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         size_ff      <= SIZE_RESET;
         rd_tag_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         size_ff      <= size_in;
         rd_tag_ff    <= rd_tag_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      count_ff     <= count_in;
      issue_ff     <= issue_in;
      qr_ff        <= qr_in;
      qg_ff        <= qg_in;
      qb_ff        <= qb_in;
      best_ff      <= best_in;
      pick_ff      <= pick_in;
      rsp_index_ff <= rsp_index_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_color_index = rsp_index_ff;

   `ASSERT_IMPLY(a_no_write_in_scan, clock, reset, state_ff == ST_SCAN, !ram_wr_en)
   `ASSERT_IMPLY(a_issue_bound, clock, reset, state_ff == ST_SCAN, issue_ff <= count_ff)
   `ASSERT_NEXT(a_best_falls, clock, reset, state_ff == ST_SCAN, best_ff <= $past(best_ff))
   `ASSERT_IMPLY(a_rsp_from_finish, clock, reset, $rose(rsp_valid_ff),
                 $past(state_ff) == ST_FINISH)

endmodule
